### rtl/ecal_pkg.sv
// shared constants, types and helpers for the epoch seconds to calendar block
// no dependencies
package ecal_pkg;

    localparam int CNT_W   = 32;
    localparam int OFS_W   = 17;
    localparam int DAYS_W  = 16;
    localparam int HMS_W   = 17;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;
    localparam int DOY_W   = 9;

    localparam int STAGES  = 8;

    localparam logic [OFS_W-1:0] ZONE_RESET = 17'd28800;

    // days = (local >> 7) / 675, exact for 25-bit operands
    localparam logic [25:0] DAY_RECIP = 26'd50903317;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    // day count from 1968-01-01 on a plain four-year cycle, with a phantom
    // 2100-02-29 inserted so dates from 2100-03-01 on land right
    localparam logic [DAYS_W-1:0] MAR_2100   = 16'd47541;
    localparam logic [DAYS_W-1:0] SHIFT_PRE  = 16'd731;
    localparam logic [DAYS_W-1:0] SHIFT_POST = 16'd732;
    localparam logic [16:0] QUAD_RECIP = 17'd91868;
    localparam logic [10:0] QUAD_DAYS  = 11'd1461;
    localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1968;

    localparam logic [17:0] HOUR_RECIP    = 18'd149131;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [12:0] MIN_RECIP     = 13'd4370;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [DAYS_W-1:0] shifted_days;
        logic [HMS_W-1:0]  hms;
        logic [WDAY_W-1:0] weekday;
    } t_split;

    // residue mod 7 by folding octal digits
    function automatic logic [WDAY_W-1:0] mod7(input logic [DAYS_W-1:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        begin
            s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
               + 6'(v[14:12]) + 6'(v[15]);
            s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
            s3 = 4'(s2[2:0]) + 4'(s2[3]);
            if (s3 >= 4'd7) begin
                return 3'(s3 - 4'd7);
            end
            return s3[2:0];
        end
    endfunction

endpackage

### rtl/ecal_split.sv
// first four pipeline stages: zone offset, day count, time of day, weekday
// depends on ecal_pkg
module ecal_split (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ecal_pkg::CNT_W-1:0]    i_counter,
    input  logic signed [ecal_pkg::OFS_W-1:0] i_offset,
    output ecal_pkg::t_split              o_split
);
    import ecal_pkg::*;

    logic [CNT_W-1:0]  r_local;
    logic [50:0]       r_dprod;
    logic [HMS_W-1:0]  r_low1;
    logic [DAYS_W-1:0] r_days;
    logic [HMS_W-1:0]  r_dmul;
    logic [HMS_W-1:0]  r_low2;
    t_split            r_split;

    logic [DAYS_W-1:0] n_days;
    logic [HMS_W-1:0]  n_dmul;
    t_split            n_split;

    always_comb begin
        n_days = r_dprod[50:35];
        n_dmul = {1'b0, n_days} * SECS_PER_DAY;
        n_split.hms = r_low2 - r_dmul;
        n_split.shifted_days = r_days + ((r_days >= MAR_2100) ? SHIFT_POST : SHIFT_PRE);
        n_split.weekday = mod7(r_days + 16'd4);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_local <= i_counter + {{(CNT_W-OFS_W){i_offset[OFS_W-1]}}, i_offset};
            r_dprod <= {26'd0, r_local[31:7]} * {25'd0, DAY_RECIP};
            r_low1  <= r_local[HMS_W-1:0];
            r_days  <= n_days;
            r_dmul  <= n_dmul;
            r_low2  <= r_low1;
            r_split <= n_split;
        end
    end

    assign o_split = r_split;

endmodule

### rtl/ecal_date.sv
// last four stages of the date path: four-year cycle, year, month, day
// depends on ecal_pkg
module ecal_date (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  ecal_pkg::t_split              i_split,
    output logic [ecal_pkg::YEAR_W-1:0]   o_year,
    output logic [ecal_pkg::MONTH_W-1:0]  o_month,
    output logic [ecal_pkg::DAY_W-1:0]    o_day,
    output logic [ecal_pkg::WDAY_W-1:0]   o_weekday
);
    import ecal_pkg::*;

    logic [32:0]        r_qprod;
    logic [DAYS_W-1:0]  r_dp;
    logic [5:0]         r_q4;
    logic [10:0]        r_r4;
    logic [YEAR_W-1:0]  r_year7;
    logic [DOY_W-1:0]   r_ry;
    logic               r_leap;
    logic [WDAY_W-1:0]  r_wd5;
    logic [WDAY_W-1:0]  r_wd6;
    logic [WDAY_W-1:0]  r_wd7;
    logic [WDAY_W-1:0]  r_wd8;
    logic [YEAR_W-1:0]  r_year8;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;

    logic [5:0]         n_q4;
    logic [16:0]        n_qmul;
    logic [16:0]        n_r4;
    logic [1:0]         n_yo;
    logic [DOY_W-1:0]   n_ry;
    logic [YEAR_W-1:0]  n_year;
    logic [DOY_W-1:0]   n_st;
    logic [MONTH_W-1:0] n_month;
    logic [DOY_W-1:0]   n_start;
    logic [DOY_W-1:0]   n_day;

    always_comb begin
        n_q4   = r_qprod[32:27];
        n_qmul = {11'd0, n_q4} * {6'd0, QUAD_DAYS};
        n_r4   = {1'b0, r_dp} - n_qmul;
    end

    always_comb begin
        if (r_r4 < 11'd366) begin
            n_yo = 2'd0;
            n_ry = r_r4[DOY_W-1:0];
        end else if (r_r4 < 11'd731) begin
            n_yo = 2'd1;
            n_ry = 9'(r_r4 - 11'd366);
        end else if (r_r4 < 11'd1096) begin
            n_yo = 2'd2;
            n_ry = 9'(r_r4 - 11'd731);
        end else begin
            n_yo = 2'd3;
            n_ry = 9'(r_r4 - 11'd1096);
        end
        n_year = BASE_YEAR + {4'd0, r_q4, 2'b00} + {10'd0, n_yo};
    end

    always_comb begin
        n_st    = '0;
        n_month = 4'd1;
        for (int i = 1; i < 12; i++) begin
            n_st = MONTH_START[i] + ((i >= 2) ? {8'd0, r_leap} : 9'd0);
            if (r_ry >= n_st) begin
                n_month = 4'(i + 1);
            end
        end
        n_start = MONTH_START[4'(n_month - 4'd1)]
                + ((n_month > 4'd2) ? {8'd0, r_leap} : 9'd0);
        n_day   = r_ry - n_start + 9'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qprod <= {17'd0, i_split.shifted_days} * {16'd0, QUAD_RECIP};
            r_dp    <= i_split.shifted_days;
            r_wd5   <= i_split.weekday;
            r_q4    <= n_q4;
            r_r4    <= n_r4[10:0];
            r_wd6   <= r_wd5;
            r_year7 <= n_year;
            r_ry    <= n_ry;
            r_leap  <= (n_yo == 2'd0);
            r_wd7   <= r_wd6;
            r_year8 <= r_year7;
            r_month <= n_month;
            r_day   <= n_day[DAY_W-1:0];
            r_wd8   <= r_wd7;
        end
    end

    assign o_year    = r_year8;
    assign o_month   = r_month;
    assign o_day     = r_day;
    assign o_weekday = r_wd8;

endmodule

### rtl/ecal_clock.sv
// last four stages of the time path: hour, minute, second
// depends on ecal_pkg
module ecal_clock (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ecal_pkg::HMS_W-1:0]   i_hms,
    output logic [ecal_pkg::HOUR_W-1:0]  o_hour,
    output logic [ecal_pkg::MIN_W-1:0]   o_minute,
    output logic [ecal_pkg::SEC_W-1:0]   o_second
);
    import ecal_pkg::*;

    logic [34:0]       r_hprod;
    logic [HMS_W-1:0]  r_hms5;
    logic [HOUR_W-1:0] r_hour6;
    logic [11:0]       r_hrem6;
    logic [24:0]       r_mprod;
    logic [11:0]       r_hrem7;
    logic [HOUR_W-1:0] r_hour7;
    logic [HOUR_W-1:0] r_hour8;
    logic [MIN_W-1:0]  r_minute;
    logic [SEC_W-1:0]  r_second;

    logic [HOUR_W-1:0] n_hour;
    logic [16:0]       n_hmul;
    logic [16:0]       n_hrem;
    logic [MIN_W-1:0]  n_minute;
    logic [11:0]       n_mmul;
    logic [11:0]       n_sec;

    always_comb begin
        n_hour   = r_hprod[33:29];
        n_hmul   = {12'd0, n_hour} * {5'd0, SECS_PER_HOUR};
        n_hrem   = r_hms5 - n_hmul;
        n_minute = r_mprod[23:18];
        n_mmul   = {6'd0, n_minute} * {6'd0, SECS_PER_MIN};
        n_sec    = r_hrem7 - n_mmul;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hprod  <= {18'd0, i_hms} * {17'd0, HOUR_RECIP};
            r_hms5   <= i_hms;
            r_hour6  <= n_hour;
            r_hrem6  <= n_hrem[11:0];
            r_mprod  <= {13'd0, r_hrem6} * {12'd0, MIN_RECIP};
            r_hrem7  <= r_hrem6;
            r_hour7  <= r_hour6;
            r_hour8  <= r_hour7;
            r_minute <= n_minute;
            r_second <= n_sec[SEC_W-1:0];
        end
    end

    assign o_hour   = r_hour8;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule

### rtl/epoch_seconds_to_calendar.sv
// top level: epoch seconds plus zone offset to local calendar date and time
// depends on ecal_pkg, ecal_split, ecal_date, ecal_clock
// pipeline: eight register stages from request to result
// throughput: one request per cycle; a result held on the output stalls all stages
// reset: synchronous active low, clears the stage valid bits and sets the offset to 28800
module epoch_seconds_to_calendar (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [ecal_pkg::CNT_W-1:0]        i_counter_seconds,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ecal_pkg::YEAR_W-1:0]       o_year,
    output logic [ecal_pkg::MONTH_W-1:0]      o_month,
    output logic [ecal_pkg::DAY_W-1:0]        o_day_of_month,
    output logic [ecal_pkg::HOUR_W-1:0]       o_hour,
    output logic [ecal_pkg::MIN_W-1:0]        o_minute,
    output logic [ecal_pkg::SEC_W-1:0]        o_second,
    output logic [ecal_pkg::WDAY_W-1:0]       o_weekday,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic signed [ecal_pkg::OFS_W-1:0] i_cfg_zone_offset_seconds
);
    import ecal_pkg::*;

    logic [STAGES-1:0]       r_vld;
    logic signed [OFS_W-1:0] r_zone;
    logic                    w_en;
    t_split                  w_split;

    assign w_en        = ~r_vld[STAGES-1] | i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[STAGES-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_zone <= ZONE_RESET;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[STAGES-2:0], i_in_valid};
            end
            if (i_cfg_valid) begin
                r_zone <= i_cfg_zone_offset_seconds;
            end
        end
    end

    ecal_split u_split (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_counter (i_counter_seconds),
        .i_offset  (r_zone),
        .o_split   (w_split)
    );

    ecal_date u_date (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_split   (w_split),
        .o_year    (o_year),
        .o_month   (o_month),
        .o_day     (o_day_of_month),
        .o_weekday (o_weekday)
    );

    ecal_clock u_clock (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_hms    (w_split.hms),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

endmodule

### rtl/ecal_checker.sv
// port-level checks for epoch_seconds_to_calendar, attached by bind
// depends on ecal_pkg and the top level's ports
module ecal_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [ecal_pkg::YEAR_W-1:0]       o_year,
    input logic [ecal_pkg::MONTH_W-1:0]      o_month,
    input logic [ecal_pkg::DAY_W-1:0]        o_day_of_month,
    input logic [ecal_pkg::HOUR_W-1:0]       o_hour,
    input logic [ecal_pkg::MIN_W-1:0]        o_minute,
    input logic [ecal_pkg::SEC_W-1:0]        o_second,
    input logic [ecal_pkg::WDAY_W-1:0]       o_weekday
);
    import ecal_pkg::*;

    // held result keeps its year, month, day and second
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_year)
            && $stable(o_month) && $stable(o_day_of_month) && $stable(o_second))
        else $error("held result changed");

    // requests wait only on a blocked result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_year >= 12'd1970 && o_year <= 12'd2106
            && o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month != 5'd0
            && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59
            && o_weekday <= 3'd6)
        else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar ecal_checker u_ecal_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_year         (o_year),
    .o_month        (o_month),
    .o_day_of_month (o_day_of_month),
    .o_hour         (o_hour),
    .o_minute       (o_minute),
    .o_second       (o_second),
    .o_weekday      (o_weekday)
);

### verif/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 100ps
// testbench for epoch_seconds_to_calendar: drives epoch counts and zone offsets,
// predicts each local calendar date in a scoreboard class and checks every result
// depends on ecal_pkg and the epoch_seconds_to_calendar rtl
module tb_epoch_seconds_to_calendar;
    import ecal_pkg::*;

    localparam int DRAIN_CYCLES   = 12;
    localparam int STALL_LIMIT    = 4000;
    localparam int RAND_PER_PHASE = 210;
    localparam int SECS_DAY       = 86400;

    localparam logic [CNT_W-1:0] DIRECTED_LOCALS [14] = '{
        32'd0, 32'hFFFF_FFFF, 32'd86399, 32'd86400, 32'd68169600,
        32'd946684800, 32'd951782399, 32'd951782400, 32'd951868800,
        32'd978307199, 32'd4107456000, 32'd4107542399, 32'd4107542400,
        32'd4291747199
    };

    localparam logic [CNT_W-1:0] EDGE_DATES [8] = '{
        32'd68169600, 32'd946684800, 32'd951782400, 32'd978307200,
        32'd4102444800, 32'd4107542400, 32'd4291747200, 32'd0
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  weekday;
    } t_calendar;

    function automatic logic [CNT_W-1:0] widen_zone(input logic signed [OFS_W-1:0] ofs);
        return {{(CNT_W-OFS_W){ofs[OFS_W-1]}}, ofs};
    endfunction

    class calendar_scoreboard;
        t_calendar   expected_dates[$];
        int          errors = 0;
        int unsigned month_first[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

        function bit leap_year(input int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function t_calendar predict_calendar(input logic [CNT_W-1:0] cnt,
                                             input logic signed [OFS_W-1:0] ofs);
            logic [CNT_W-1:0] local_secs;
            int unsigned days, hms, rest, yr, ylen, mon, leap_add, first;
            t_calendar c;
            local_secs = cnt + widen_zone(ofs);
            days = local_secs / SECS_DAY;
            hms  = local_secs % SECS_DAY;
            rest = days;
            yr   = 1970;
            ylen = leap_year(yr) ? 366 : 365;
            while (rest >= ylen) begin
                rest -= ylen;
                yr++;
                ylen = leap_year(yr) ? 366 : 365;
            end
            leap_add = leap_year(yr) ? 1 : 0;
            mon = 1;
            for (int m = 1; m < 12; m++) begin
                if (rest >= month_first[m] + ((m >= 2) ? leap_add : 0)) begin
                    mon = m + 1;
                end
            end
            first = month_first[mon-1] + ((mon > 2) ? leap_add : 0);
            c.year         = YEAR_W'(yr);
            c.month        = MONTH_W'(mon);
            c.day_of_month = DAY_W'(rest - first + 1);
            c.hour         = HOUR_W'(hms / 3600);
            c.minute       = MIN_W'((hms % 3600) / 60);
            c.second       = SEC_W'(hms % 60);
            c.weekday      = WDAY_W'((days + 4) % 7);
            return c;
        endfunction

        function void note_request(input logic [CNT_W-1:0] cnt,
                                   input logic signed [OFS_W-1:0] ofs);
            expected_dates.push_back(predict_calendar(cnt, ofs));
        endfunction

        function void check_field(input string name, input int unsigned want,
                                  input int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input t_calendar got);
            t_calendar want;
            if (expected_dates.size() == 0) begin
                $error("result with no request pending");
                errors++;
                return;
            end
            want = expected_dates.pop_front();
            check_field("year", want.year, got.year);
            check_field("month", want.month, got.month);
            check_field("day_of_month", want.day_of_month, got.day_of_month);
            check_field("hour", want.hour, got.hour);
            check_field("minute", want.minute, got.minute);
            check_field("second", want.second, got.second);
            check_field("weekday", want.weekday, got.weekday);
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [CNT_W-1:0]         i_counter_seconds = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [YEAR_W-1:0]        o_year;
    logic [MONTH_W-1:0]       o_month;
    logic [DAY_W-1:0]         o_day_of_month;
    logic [HOUR_W-1:0]        o_hour;
    logic [MIN_W-1:0]         o_minute;
    logic [SEC_W-1:0]         o_second;
    logic [WDAY_W-1:0]        o_weekday;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic signed [OFS_W-1:0]  i_cfg_zone_offset_seconds = '0;

    logic signed [OFS_W-1:0]  zone_ofs = ZONE_RESET;
    bit                       quiet = 1'b0;
    int                       stall_cycles = 0;
    calendar_scoreboard       sb = new();

    epoch_seconds_to_calendar u_top (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_in_valid                (i_in_valid),
        .o_in_ready                (o_in_ready),
        .i_counter_seconds         (i_counter_seconds),
        .o_out_valid               (o_out_valid),
        .i_out_ready               (i_out_ready),
        .o_year                    (o_year),
        .o_month                   (o_month),
        .o_day_of_month            (o_day_of_month),
        .o_hour                    (o_hour),
        .o_minute                  (o_minute),
        .o_second                  (o_second),
        .o_weekday                 (o_weekday),
        .i_cfg_valid               (i_cfg_valid),
        .o_cfg_ready               (o_cfg_ready),
        .i_cfg_zone_offset_seconds (i_cfg_zone_offset_seconds)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(0, 99) >= 7);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_counter_seconds, zone_ofs);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_year, o_month, o_day_of_month, o_hour,
                                 o_minute, o_second, o_weekday});
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic [CNT_W-1:0] cnt);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_counter_seconds <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // aim at a local time under the current offset
    task automatic send_local(input logic [CNT_W-1:0] local_target);
        send_request(local_target - widen_zone(zone_ofs));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_zone(input logic signed [OFS_W-1:0] ofs);
        wait_drained();
        i_cfg_valid               <= 1'b1;
        i_cfg_zone_offset_seconds <= ofs;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        zone_ofs = ofs;
    endtask

    function automatic logic [CNT_W-1:0] pick_local();
        int unsigned sel;
        int unsigned day;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return $urandom();
        end else if (sel < 8) begin
            // around midnight
            day = $urandom_range(0, 49710);
            return CNT_W'(day) * CNT_W'(SECS_DAY) + CNT_W'($urandom_range(0, 4)) - 2;
        end
        // within two months of a leap-day or year boundary
        return EDGE_DATES[$urandom_range(0, 7)] + CNT_W'($urandom_range(0, 10368000))
               - 32'd5184000;
    endfunction

    task automatic random_phase(input int count);
        repeat (count) send_local(pick_local());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset offset
        foreach (DIRECTED_LOCALS[i]) send_local(DIRECTED_LOCALS[i]);
        send_request('0);
        send_request('1);
        random_phase(RAND_PER_PHASE);

        // westmost zone, local time wraps below zero
        write_zone(-17'sd43200);
        send_request('0);
        send_request(32'd43199);
        random_phase(RAND_PER_PHASE);

        // eastmost zone, local time wraps past the top
        write_zone(17'sd50400);
        send_request('1);
        send_request(32'hFFFF_FFFF - 32'd50399);
        random_phase(RAND_PER_PHASE);

        // utc with no idling on either side
        write_zone('0);
        quiet = 1'b1;
        foreach (DIRECTED_LOCALS[i]) send_local(DIRECTED_LOCALS[i]);
        random_phase(RAND_PER_PHASE);
        quiet = 1'b0;

        // offsets beyond the usual zone range
        write_zone(17'sh10000);
        send_request('0);
        send_request('1);
        random_phase(RAND_PER_PHASE);

        write_zone(17'sh0FFFF);
        send_request('0);
        send_request('1);
        random_phase(RAND_PER_PHASE);

        write_zone(OFS_W'(int'($urandom_range(0, 93600)) - 43200));
        random_phase(RAND_PER_PHASE);

        write_zone(OFS_W'($urandom()));
        random_phase(RAND_PER_PHASE);

        write_zone(OFS_W'(int'($urandom_range(0, 93600)) - 43200));
        random_phase(RAND_PER_PHASE);

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### epoch_seconds_to_calendar.f
rtl/ecal_pkg.sv
rtl/ecal_split.sv
rtl/ecal_date.sv
rtl/ecal_clock.sv
rtl/epoch_seconds_to_calendar.sv
rtl/ecal_checker.sv
verif/tb_epoch_seconds_to_calendar.sv
